// File: rtl/command_decoder_job_queue_macros.svh
// assertion helpers used by cdjq_ctrl
`ifndef COMMAND_DECODER_JOB_QUEUE_MACROS_SVH
`define COMMAND_DECODER_JOB_QUEUE_MACROS_SVH

// same-cycle implication
`define CDJQ_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("cdjq assertion failed");

// next-cycle implication
`define CDJQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("cdjq assertion failed");

`endif

// File: rtl/cdjq_pkg.sv
package cdjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;
    localparam logic [1:0] OP_DONE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CODE    = 3'd1;
    localparam logic [2:0] ST_ID      = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_PENDING = 3'd6;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [1:0] CFG_MAX_X    = 2'd0;
    localparam logic [1:0] CFG_MAX_Y    = 2'd1;
    localparam logic [1:0] CFG_MAX_Z    = 2'd2;
    localparam logic [1:0] CFG_MAX_GRIP = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] msg_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  opcode;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] joint;
        logic [15:0] grip;
        logic [31:0] check;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] job_id;
        logic [7:0]  job_opcode;
        logic [15:0] job_x;
        logic [15:0] job_y;
        logic [15:0] job_z;
        logic [15:0] job_joint;
        logic [15:0] job_gripper;
        logic [31:0] job_check;
    } t_out;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_ctl;

    typedef struct packed {
        logic has_result;
    } t_sts;

endpackage

// File: rtl/cdjq_ctrl.sv
`include "command_decoder_job_queue_macros.svh"

module cdjq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  cdjq_pkg::t_sts i_sts,
    output cdjq_pkg::t_ctl o_ctl
);
    import cdjq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    always_comb begin
        out_free      = !r_out_valid || !i_out_stall;
        o_in_stall    = (r_state != S_IDLE);
        o_ctl.accept  = i_in_valid && (r_state == S_IDLE);
        o_ctl.exec    = (r_state == S_EXEC) && (!i_sts.has_result || out_free);
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_ctl.accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_ctl.exec) begin
                    n_state = S_IDLE;
                    if (i_sts.has_result) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `CDJQ_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, o_ctl.accept, r_state == S_EXEC)
    `CDJQ_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_ctl.exec && i_sts.has_result, !r_out_valid || !i_out_stall)
    `CDJQ_ASSERT_NOW(a_exec_only_busy, i_clk, i_rst_n, o_ctl.exec, r_state == S_EXEC && !o_ctl.accept)
    `CDJQ_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, o_ctl.exec && i_sts.has_result, r_out_valid)

endmodule

// File: rtl/cdjq_dp.sv
module cdjq_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cdjq_pkg::t_in  i_in_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  cdjq_pkg::t_ctl i_ctl,
    output cdjq_pkg::t_sts o_sts,
    output cdjq_pkg::t_out o_out_data
);
    import cdjq_pkg::*;

    localparam logic [1:0] PH_ID     = 2'd0;
    localparam logic [1:0] PH_FIELDS = 2'd1;
    localparam logic [1:0] PH_CHECK  = 2'd2;

    function automatic logic [31:0] add_digit(logic [31:0] v, logic [3:0] d,
                                              logic [31:0] maxv);
        logic [35:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d};
        add_digit = (n > {4'd0, maxv}) ? maxv : n[31:0];
    endfunction

    function automatic t_out make_out(logic [2:0] st, t_job j);
        make_out = '{status: st, job_id: j.id, job_opcode: j.opcode, job_x: j.x,
                     job_y: j.y, job_z: j.z, job_joint: j.joint,
                     job_gripper: j.grip, job_check: j.check};
    endfunction

    t_in         r_item;
    t_job        r_slot [QUEUE_DEPTH];
    t_job        r_cur;
    t_job        r_dec;
    logic        r_dec_valid;
    logic [1:0]  r_phase;
    logic [3:0]  r_field;
    logic        r_stop;
    logic        r_dup;
    logic [15:0] r_max_x, r_max_y, r_max_z, r_max_grip;
    t_out        r_out;

    t_job              dec_base, dec_upd;
    logic              is_digit;
    logic [3:0]        dval;
    logic [31:0]       cur_val, max_val, new_val;
    logic [2:0]        judge;
    logic [QIDX_W-1:0] free_idx;
    logic              has_free;
    logic              dup;

    always_comb begin
        o_sts.has_result = (r_item.operation != OP_BYTE) || (r_item.msg_byte == CH_NEWLINE);
        dec_base = r_dec_valid ? '0 : r_dec;
        is_digit = (r_item.msg_byte >= CH_ZERO) && (r_item.msg_byte <= CH_NINE);
        dval     = r_item.msg_byte[3:0];
        cur_val  = '0;
        max_val  = 32'd65535;
        if (r_phase == PH_ID) begin
            cur_val = {16'd0, dec_base.id};
        end else if (r_phase == PH_CHECK) begin
            cur_val = dec_base.check;
            max_val = 32'hFFFF_FFFF;
        end else begin
            case (r_field)
                4'd0: begin
                    cur_val = {24'd0, dec_base.opcode};
                    max_val = 32'd255;
                end
                4'd1: cur_val = {16'd0, dec_base.x};
                4'd2: cur_val = {16'd0, dec_base.y};
                4'd3: cur_val = {16'd0, dec_base.z};
                4'd4: cur_val = {16'd0, dec_base.joint};
                4'd5: cur_val = {16'd0, dec_base.grip};
                default: cur_val = '0;
            endcase
        end
        new_val = add_digit(cur_val, dval, max_val);
        dec_upd = dec_base;
        if (r_phase == PH_ID) begin
            dec_upd.id = new_val[15:0];
        end else if (r_phase == PH_CHECK) begin
            dec_upd.check = new_val;
        end else begin
            case (r_field)
                4'd0: dec_upd.opcode = new_val[7:0];
                4'd1: dec_upd.x      = new_val[15:0];
                4'd2: dec_upd.y      = new_val[15:0];
                4'd3: dec_upd.z      = new_val[15:0];
                4'd4: dec_upd.joint  = new_val[15:0];
                4'd5: dec_upd.grip   = new_val[15:0];
                default: dec_upd = dec_base;
            endcase
        end

        // id 0 matches any free slot
        if (r_dup) begin
            judge = ST_ID;
        end else if (r_dec.opcode < 8'd1 || r_dec.opcode > 8'd4) begin
            judge = ST_INVALID;
        end else if (r_dec.opcode <= 8'd3 &&
                     (r_dec.x == '0 || r_dec.y == '0 || r_dec.z == '0 ||
                      r_dec.grip == '0 || r_dec.joint != '0 ||
                      r_dec.x > r_max_x || r_dec.y > r_max_y ||
                      r_dec.z > r_max_z || r_dec.grip > r_max_grip)) begin
            judge = ST_INVALID;
        end else begin
            judge = ST_OK;
        end

        free_idx = '0;
        has_free = 1'b0;
        dup      = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (r_slot[i].id == '0) begin
                free_idx = QIDX_W'(i);
                has_free = 1'b1;
            end
            if (r_slot[i].id == r_dec.id) begin
                dup = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dup <= dup;
        if (i_ctl.accept) begin
            r_item <= i_in_data;
        end
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slot[i] <= '0;
            end
            r_cur       <= '0;
            r_dec       <= '0;
            r_dec_valid <= 1'b0;
            r_phase     <= PH_ID;
            r_field     <= '0;
            r_stop      <= 1'b0;
            r_max_x     <= 16'hFFFF;
            r_max_y     <= 16'hFFFF;
            r_max_z     <= 16'hFFFF;
            r_max_grip  <= 16'hFFFF;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_X:    r_max_x    <= i_cfg_data;
                    CFG_MAX_Y:    r_max_y    <= i_cfg_data;
                    CFG_MAX_Z:    r_max_z    <= i_cfg_data;
                    CFG_MAX_GRIP: r_max_grip <= i_cfg_data;
                    default: r_max_x <= r_max_x;
                endcase
            end
            if (i_ctl.exec) begin
                unique case (r_item.operation)
                    OP_BYTE: begin
                        if (r_item.msg_byte == CH_NEWLINE) begin
                            r_phase <= PH_ID;
                            r_field <= '0;
                            r_stop  <= 1'b0;
                            if (r_phase == PH_CHECK && judge == ST_OK) begin
                                r_dec_valid <= 1'b1;
                                r_dec       <= dec_base;
                                r_out       <= make_out(ST_OK, dec_base);
                            end else begin
                                r_dec_valid <= 1'b0;
                                r_dec       <= '0;
                                r_out <= make_out((r_phase == PH_CHECK) ? judge : ST_CODE,
                                                  '0);
                            end
                        end else begin
                            r_dec_valid <= 1'b0;
                            // separators are never digits, so only digits grow a field
                            r_dec <= (is_digit && !r_stop) ? dec_upd : dec_base;
                            if (r_phase == PH_ID) begin
                                if (r_item.msg_byte == CH_LBRACKET) begin
                                    r_phase <= PH_FIELDS;
                                    r_field <= '0;
                                    r_stop  <= 1'b0;
                                end else if (!is_digit) begin
                                    r_stop <= 1'b1;
                                end
                            end else if (r_phase == PH_FIELDS) begin
                                if (r_item.msg_byte == CH_RBRACKET) begin
                                    r_phase <= PH_CHECK;
                                    r_stop  <= 1'b0;
                                end else if (r_item.msg_byte == CH_COMMA) begin
                                    if (r_field != 4'd15) begin
                                        r_field <= r_field + 4'd1;
                                    end
                                    r_stop <= 1'b0;
                                end else if (!is_digit) begin
                                    r_stop <= 1'b1;
                                end
                            end else begin
                                if (!is_digit) begin
                                    r_stop <= 1'b1;
                                end
                            end
                        end
                    end
                    OP_ADD: begin
                        if (!r_dec_valid) begin
                            r_out <= make_out(ST_INVALID, '0);
                        end else if (has_free) begin
                            r_slot[free_idx] <= r_dec;
                            r_out            <= make_out(ST_OK, r_dec);
                            r_dec            <= '0;
                            r_dec_valid      <= 1'b0;
                        end else begin
                            r_out <= make_out(ST_FULL, r_dec);
                        end
                    end
                    OP_TAKE: begin
                        if (r_cur.id != '0) begin
                            r_out <= make_out(ST_PENDING, r_cur);
                        end else if (r_slot[0].id == '0) begin
                            r_out <= make_out(ST_EMPTY, '0);
                        end else begin
                            r_cur <= r_slot[0];
                            r_out <= make_out(ST_OK, r_slot[0]);
                            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                                r_slot[i] <= (r_slot[i + 1].id == '0) ? '0 : r_slot[i + 1];
                            end
                            r_slot[QUEUE_DEPTH - 1] <= '0;
                        end
                    end
                    OP_DONE: begin
                        r_cur <= '0;
                        r_out <= make_out(ST_OK, '0);
                    end
                    default: r_cur <= r_cur;
                endcase
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// File: rtl/command_decoder_job_queue.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | i_in_data (operation, msg_byte)
// out     | output     | o_out_valid / i_out_stall  | o_out_data (status and job fields)
// cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// each transaction is accepted, then executed in the datapath before the next is accepted
// the duplicate id search over the queue slots is registered
// execute waits while a finished result is still stalled at the output register
// synchronous active-low reset clears the queue, current and decoded jobs and sets the limits to 16'hFFFF

module command_decoder_job_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cdjq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cdjq_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import cdjq_pkg::*;

    t_ctl ctl;
    t_sts sts;

    cdjq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    cdjq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

// File: tb/sv/command_decoder_job_queue_checker.sv
`timescale 1ns / 1ps

module command_decoder_job_queue_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  cdjq_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  cdjq_pkg::t_out i_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);
    import cdjq_pkg::*;

    logic [15:0] lim_x, lim_y, lim_z, lim_grip;
    t_job        queue_slots [QUEUE_DEPTH];
    t_job        cur_job, parsed_job;
    logic        parsed_ok;
    logic [1:0]  phase;
    logic [3:0]  field_no;
    logic        digits_done;
    t_out        expected_results [$];

    assign o_pending = expected_results.size();

    function automatic logic [31:0] push_digit(logic [31:0] v, logic [7:0] c,
                                               logic [31:0] maxv);
        logic [35:0] n;
        n = v * 36'd10 + 36'(c - CH_ZERO);
        return (n > {4'd0, maxv}) ? maxv : n[31:0];
    endfunction

    function automatic t_out make_result(logic [2:0] st, t_job j);
        t_out r;
        r = {st, j.id, j.opcode, j.x, j.y, j.z, j.joint, j.grip, j.check};
        return r;
    endfunction

    function automatic logic [2:0] judge_line();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (queue_slots[i].id == parsed_job.id) return ST_ID;
        if (parsed_job.opcode < 1 || parsed_job.opcode > 4) return ST_INVALID;
        if (parsed_job.opcode <= 3) begin
            if (parsed_job.x == 0 || parsed_job.y == 0 || parsed_job.z == 0 ||
                parsed_job.grip == 0 || parsed_job.joint != 0) return ST_INVALID;
            if (parsed_job.x > lim_x || parsed_job.y > lim_y || parsed_job.z > lim_z ||
                parsed_job.grip > lim_grip) return ST_INVALID;
        end
        return ST_OK;
    endfunction

    task automatic predict_byte(logic [7:0] c);
        logic       is_digit;
        logic [2:0] st;
        is_digit = c >= CH_ZERO && c <= CH_NINE;
        if (parsed_ok) begin
            parsed_job = '0;
            parsed_ok  = 1'b0;
        end
        if (c == CH_NEWLINE) begin
            st = (phase == 2'd2) ? judge_line() : ST_CODE;
            phase = 2'd0; field_no = '0; digits_done = 1'b0;
            if (st == ST_OK) begin
                parsed_ok = 1'b1;
                expected_results.push_back(make_result(st, parsed_job));
            end else begin
                parsed_job = '0;
                expected_results.push_back(make_result(st, '0));
            end
        end else if (phase == 2'd0) begin
            if (c == CH_LBRACKET) begin
                phase = 2'd1; field_no = '0; digits_done = 1'b0;
            end else if (is_digit && !digits_done) begin
                parsed_job.id = 16'(push_digit(parsed_job.id, c, 32'hFFFF));
            end else begin
                digits_done = 1'b1;
            end
        end else if (phase == 2'd1) begin
            if (c == CH_RBRACKET) begin
                phase = 2'd2; digits_done = 1'b0;
            end else if (c == CH_COMMA) begin
                if (field_no < 15) field_no++;
                digits_done = 1'b0;
            end else if (is_digit && !digits_done) begin
                case (field_no)
                    0: parsed_job.opcode = 8'(push_digit(parsed_job.opcode, c, 32'hFF));
                    1: parsed_job.x      = 16'(push_digit(parsed_job.x, c, 32'hFFFF));
                    2: parsed_job.y      = 16'(push_digit(parsed_job.y, c, 32'hFFFF));
                    3: parsed_job.z      = 16'(push_digit(parsed_job.z, c, 32'hFFFF));
                    4: parsed_job.joint  = 16'(push_digit(parsed_job.joint, c, 32'hFFFF));
                    5: parsed_job.grip   = 16'(push_digit(parsed_job.grip, c, 32'hFFFF));
                    default: ;
                endcase
            end else begin
                digits_done = 1'b1;
            end
        end else begin
            if (is_digit && !digits_done)
                parsed_job.check = push_digit(parsed_job.check, c, 32'hFFFFFFFF);
            else
                digits_done = 1'b1;
        end
    endtask

    task automatic predict_item(t_in item);
        int slot;
        case (item.operation)
            OP_BYTE: predict_byte(item.msg_byte);
            OP_ADD: begin
                slot = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (slot < 0 && queue_slots[i].id == 0) slot = i;
                if (!parsed_ok) begin
                    expected_results.push_back(make_result(ST_INVALID, '0));
                end else if (slot < 0) begin
                    expected_results.push_back(make_result(ST_FULL, parsed_job));
                end else begin
                    queue_slots[slot] = parsed_job;
                    expected_results.push_back(make_result(ST_OK, parsed_job));
                    parsed_job = '0;
                    parsed_ok  = 1'b0;
                end
            end
            OP_TAKE: begin
                if (cur_job.id != 0) begin
                    expected_results.push_back(make_result(ST_PENDING, cur_job));
                end else if (queue_slots[0].id == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, '0));
                end else begin
                    cur_job = queue_slots[0];
                    // every job shifts up one slot; a free slot moves up as a cleared slot
                    for (int i = 0; i + 1 < QUEUE_DEPTH; i++)
                        queue_slots[i] = (queue_slots[i + 1].id == 0) ? '0 : queue_slots[i + 1];
                    queue_slots[QUEUE_DEPTH - 1] = '0;
                    expected_results.push_back(make_result(ST_OK, cur_job));
                end
            end
            default: begin
                cur_job = '0;
                expected_results.push_back(make_result(ST_OK, '0));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    task automatic compare_result(t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", got.status, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)           report_mismatch("status", got.status, want.status);
        if (got.job_id !== want.job_id)           report_mismatch("job_id", got.job_id, want.job_id);
        if (got.job_opcode !== want.job_opcode)   report_mismatch("opcode", got.job_opcode, want.job_opcode);
        if (got.job_x !== want.job_x)             report_mismatch("x", got.job_x, want.job_x);
        if (got.job_y !== want.job_y)             report_mismatch("y", got.job_y, want.job_y);
        if (got.job_z !== want.job_z)             report_mismatch("z", got.job_z, want.job_z);
        if (got.job_joint !== want.job_joint)     report_mismatch("joint", got.job_joint, want.job_joint);
        if (got.job_gripper !== want.job_gripper) report_mismatch("gripper", got.job_gripper, want.job_gripper);
        if (got.job_check !== want.job_check)     report_mismatch("check", got.job_check, want.job_check);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_x = 16'hFFFF; lim_y = 16'hFFFF; lim_z = 16'hFFFF; lim_grip = 16'hFFFF;
            for (int i = 0; i < QUEUE_DEPTH; i++) queue_slots[i] = '0;
            cur_job = '0; parsed_job = '0; parsed_ok = 1'b0;
            phase = 2'd0; field_no = '0; digits_done = 1'b0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_X: lim_x = i_cfg_data;
                    CFG_MAX_Y: lim_y = i_cfg_data;
                    CFG_MAX_Z: lim_z = i_cfg_data;
                    default:   lim_grip = i_cfg_data;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_data);
        end
    end
endmodule

// File: tb/sv/command_decoder_job_queue_tb.sv
`timescale 1ns / 1ps

module command_decoder_job_queue_tb;
    import cdjq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_MAX_X;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        hold_output = 1'b0;
    logic        no_gaps = 1'b0;
    int          items_sent = 0;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    command_decoder_job_queue uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    command_decoder_job_queue_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stall per transaction, or one long hold-off on request
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_output && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (out_valid && !out_stall) begin
                gap = no_gaps ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap - 1) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("command_decoder_job_queue_tb: errors");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, msg_byte: b};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                                logic [15:0] mg);
        logic [15:0] vals [4];
        vals = '{mx, my, mz, mg};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic string rand_num(int maxv);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return "0";
        if (kind == 1) return $sformatf("%0d", maxv);
        if (kind == 2) return "99999999999";
        return $sformatf("%0d", $urandom_range(1, maxv));
    endfunction

    function automatic string rand_line();
        string s;
        int    op;
        op = $urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(0, 300);
        s = $sformatf("%0d[%0d,%s,%s,%s,%s,%s", $urandom_range(0, 12) == 0 ? 0 :
                      $urandom_range(1, 400), op, rand_num(300), rand_num(300),
                      rand_num(300), ($urandom_range(0, 5) == 0) ? rand_num(20) : "0",
                      rand_num(300));
        if ($urandom_range(0, 4) == 0) s = {s, ",7,8"};
        s = {s, "]", rand_num(1000000), "\n"};
        return s;
    endfunction

    function automatic string corrupt_line(string s);
        int i;
        i = $urandom_range(0, s.len() - 2);
        case ($urandom_range(0, 2))
            0: s[i] = 8'($urandom_range(0, 255));
            1: s = {s.substr(0, i - 1), "\n"};
            default: s = {s.substr(0, i), "x", s.substr(i + 1, s.len() - 1)};
        endcase
        return s;
    endfunction

    initial begin
        int op;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each status but full, saturation, missing brackets
        no_gaps <= 1'b1;
        send_item(OP_TAKE, 8'h00);
        send_item(OP_ADD, 8'hFF);
        send_text("99999[999,99999,1,1,0,99999,5,6]99999999999\n");
        send_item(OP_ADD, 8'h00);
        send_text("0[4]\n5,[1]\n7[1,1,1,1\n");
        send_text("8[2,1,1,1,3,1]\n");
        no_gaps <= 1'b0;
        send_text("6[4,0,0,0,9,0]77\n");
        send_item(OP_ADD, 8'h00);
        send_text("6[4]\n");
        send_item(OP_TAKE, 8'h00);
        send_item(OP_TAKE, 8'h00);
        send_item(OP_DONE, 8'h00);
        send_item(OP_TAKE, 8'h00);
        drain_results();

        write_limits(16'd0, 16'd0, 16'd0, 16'd0);
        send_text("3[1,1,1,1,0,1]\n3[4,1,1,1,0,1]\n");
        send_item(OP_ADD, 8'h00);
        drain_results();
        write_limits(16'd150, 16'd200, 16'd250, 16'd100);

        // fill the queue with the receiver held off, input backs up
        hold_output <= 1'b1;
        for (int n = 0; n < 20; n++) begin
            send_text($sformatf("%0d[4,1,2,3,4,5]%0d\n", 1000 + n, n));
            send_item(OP_ADD, 8'h00);
        end
        repeat (200) @(posedge clk);
        hold_output <= 1'b0;
        drain_results();

        while (items_sent < 1400) begin
            if ($urandom_range(0, 2) == 0) begin
                for (int k = 0; k < 12; k++) send_item(OP_BYTE, 8'($urandom));
            end else begin
                send_text($urandom_range(0, 4) == 0 ? corrupt_line(rand_line()) : rand_line());
            end
            op = $urandom_range(0, 9);
            if (op < 5) send_item(OP_ADD, 8'($urandom));
            else if (op < 8) send_item(OP_TAKE, 8'($urandom));
            else send_item(OP_DONE, 8'($urandom));
            if ($urandom_range(0, 60) == 0) begin
                drain_results();
                write_limits(16'($urandom), 16'($urandom),
                             $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom),
                             16'($urandom));
            end
        end
        drain_results();
        write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_text("42[1,65535,65535,65535,0,65535]1\n");
        send_item(OP_ADD, 8'h00);
        drain_results();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("command_decoder_job_queue_tb: clean");
        else
            $display("command_decoder_job_queue_tb: errors");
        $finish;
    end
endmodule
